// ===== src/hrp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types and constants of the HTTP request head parser: parse phases,
// result status codes, method codes and the fixed text that is matched.
// ----------------------------------------------------------------------------
package hrp_pkg;

  // Longest method name accepted before the space
  localparam int unsigned MAX_METHOD_CHARS = 7;
  localparam int unsigned NUM_VERBS        = 9;

  // Characters used by the parser
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Parse phase
  typedef enum logic [3:0] {
    PH_METHOD   = 4'd0,
    PH_PATH     = 4'd1,
    PH_PROTO    = 4'd2,
    PH_MAJOR    = 4'd3,
    PH_DOT      = 4'd4,
    PH_MINOR    = 4'd5,
    PH_CR       = 4'd6,
    PH_LF       = 4'd7,
    PH_LINE     = 4'd8,
    PH_KEY      = 4'd9,
    PH_SPACE    = 4'd10,
    PH_VALUE    = 4'd11,
    PH_VALUE_LF = 4'd12,
    PH_END_LF   = 4'd13
  } phase_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_METHOD   = 3'd1,
    ST_BAD_LINE     = 3'd2,
    ST_BAD_VERSION  = 3'd3,
    ST_BAD_HEADER   = 3'd4,
    ST_BAD_LENGTH   = 3'd5,
    ST_LEN_OVERFLOW = 3'd6
  } status_e;

  // Method names, one row per method code, zero padded
  localparam logic [7:0] VERB_TEXT [NUM_VERBS][8] = '{
    '{"G", "E", "T", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"H", "E", "A", "D",  8'h0, 8'h0, 8'h0, 8'h0},
    '{"P", "O", "S", "T",  8'h0, 8'h0, 8'h0, 8'h0},
    '{"P", "U", "T", 8'h0, 8'h0, 8'h0, 8'h0, 8'h0},
    '{"D", "E", "L", "E",  "T",  "E",  8'h0, 8'h0},
    '{"C", "O", "N", "N",  "E",  "C",  "T",  8'h0},
    '{"O", "P", "T", "I",  "O",  "N",  "S",  8'h0},
    '{"T", "R", "A", "C",  "E",  8'h0, 8'h0, 8'h0},
    '{"P", "A", "T", "C",  "H",  8'h0, 8'h0, 8'h0}
  };
  localparam logic [3:0] VERB_LEN [NUM_VERBS] = '{
    4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd5, 4'd5
  };

  localparam logic [7:0] PROTO_TEXT [5] = '{"H", "T", "T", "P", "/"};
  localparam logic [3:0] PROTO_LEN      = 4'd5;

  localparam logic [7:0] LEN_KEY [14] = '{
    "C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t", "h"
  };
  localparam logic [3:0] LEN_KEY_LEN = 4'd14;

  localparam logic [7:0] CONN_KEY [10] = '{
    "C", "o", "n", "n", "e", "c", "t", "i", "o", "n"
  };
  localparam logic [3:0] CONN_KEY_LEN = 4'd10;

  localparam logic [7:0] KA_TEXT [10] = '{
    "K", "e", "e", "p", "-", "A", "l", "i", "v", "e"
  };
  localparam logic [3:0] KA_LEN = 4'd10;

  // Parser control state (the length accumulator travels separately)
  typedef struct packed {
    phase_e         phase;
    logic [3:0]     pos;
    logic [NUM_VERBS-1:0] cand;
    logic [1:0]     kflags;   // bit 0 Content-Length, bit 1 Connection
    logic           vmatch;
    logic           dseen;
    logic           kalive;
    logic [3:0]     method;
    logic [1:0]     major;
    logic [1:0]     minor;
  } hrp_state_t;

  localparam hrp_state_t STATE_RESET = '{
    phase:  PH_METHOD,
    pos:    4'd0,
    cand:   {NUM_VERBS{1'b1}},
    kflags: 2'b11,
    vmatch: 1'b1,
    dseen:  1'b0,
    kalive: 1'b0,
    method: 4'd0,
    major:  2'd0,
    minor:  2'd0
  };

  // Step outcome: a result is due, and its status
  typedef struct packed {
    logic    fire;
    status_e status;
  } hrp_result_t;

endpackage

// ===== src/http_request_head_parser_unit.sv =====
// ----------------------------------------------------------------------------
// http_request_head_parser_unit
// Byte-stream parser for an HTTP/1.x request head with a registered result.
// ----------------------------------------------------------------------------
// The unit takes one byte per cycle and holds one result register. A result
// (status, method, version, Content-Length and keep-alive) appears on the
// output in the cycle after the byte that ends the head or reveals an error;
// the parser then starts over on the next byte. Throughput is one byte per
// clock, as the parser state register is updated on every accepted byte;
// input ready drops only while a result is held and the output is stalled.
// body_length carries the low 32 bits of the LENGTH_WIDTH-bit accumulator.
module http_request_head_parser_unit #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  method_code_o,
  output logic [1:0]  major_version_o,
  output logic [1:0]  minor_version_o,
  output logic [31:0] body_length_o,
  output logic        persistent_o
);
  import hrp_pkg::*;

  hrp_state_t              state_q, state_d;
  logic [LENGTH_WIDTH-1:0] acc_q, acc_d;
  hrp_result_t             res;
  logic                    in_fire;
  logic                    out_valid_q;
  logic [LENGTH_WIDTH+31:0] acc_ext;

  // Per-byte next-state logic
  hrp_step #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_step (
    .cur_i (state_q),
    .acc_i (acc_q),
    .byte_i(in_byte_i),
    .nxt_o (state_d),
    .acc_o (acc_d),
    .res_o (res)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign acc_ext    = {32'd0, acc_q};

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
      acc_q   <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_fire && res.fire;
    end
  end

  // Result payload, taken from the state gathered before the final byte
  always_ff @(posedge clk_i) begin
    if (in_fire && res.fire) begin
      status_o        <= res.status;
      method_code_o   <= state_q.method;
      major_version_o <= state_q.major;
      minor_version_o <= state_q.minor;
      body_length_o   <= acc_ext[31:0];
      persistent_o    <= state_q.kalive;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/hrp_step.sv =====
// ----------------------------------------------------------------------------
// hrp_step
// Next-state logic of the parser: applies one byte to the current state and
// flags a result when the head ends or an error is found.
// ----------------------------------------------------------------------------
module hrp_step #(
  parameter int unsigned LENGTH_WIDTH = 32
) (
  input  hrp_pkg::hrp_state_t  cur_i,
  input  logic [LENGTH_WIDTH-1:0] acc_i,
  input  logic [7:0]           byte_i,
  output hrp_pkg::hrp_state_t  nxt_o,
  output logic [LENGTH_WIDTH-1:0] acc_o,
  output hrp_pkg::hrp_result_t res_o
);
  import hrp_pkg::*;

  logic [NUM_VERBS-1:0] keep;
  logic                 space_hit;
  logic [3:0]           space_idx;
  logic                 len_hit, conn_hit, ka_hit;
  logic [3:0]           pos_inc, pos_inc2;
  logic                 is_digit;
  logic [LENGTH_WIDTH+3:0] prod;
  logic                 ovf;

  // Method candidate filtering and the exact-length match on space
  always_comb begin
    space_hit = 1'b0;
    space_idx = '0;
    for (int i = NUM_VERBS - 1; i >= 0; i--) begin
      keep[i] = cur_i.cand[i] && (cur_i.pos < VERB_LEN[i]) &&
                (VERB_TEXT[i][cur_i.pos[2:0]] == byte_i);
      if (cur_i.cand[i] && (VERB_LEN[i] == cur_i.pos)) begin
        space_hit = 1'b1;
        space_idx = 4'(i);
      end
    end
  end

  // Key and value text compares at the current position
  assign len_hit  = (cur_i.pos < LEN_KEY_LEN) && (LEN_KEY[cur_i.pos] == byte_i);
  assign conn_hit = (cur_i.pos < CONN_KEY_LEN) && (CONN_KEY[cur_i.pos] == byte_i);
  assign ka_hit   = (cur_i.pos < KA_LEN) && (KA_TEXT[cur_i.pos] == byte_i);

  // Saturating position advance by one and by two
  assign pos_inc  = (cur_i.pos == 4'hF) ? 4'hF : cur_i.pos + 4'd1;
  assign pos_inc2 = (pos_inc == 4'hF) ? 4'hF : pos_inc + 4'd1;

  // Decimal accumulate: acc * 10 + digit, overflow if upper bits are set
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign prod = {1'b0, acc_i, 3'b000} + {3'b000, acc_i, 1'b0} +
                {(LENGTH_WIDTH)'(0), byte_i[3:0]};
  assign ovf  = (prod[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'd0);

  always_comb begin
    nxt_o         = cur_i;
    acc_o         = acc_i;
    res_o.fire    = 1'b0;
    res_o.status  = ST_OK;

    unique case (cur_i.phase)
      PH_METHOD: begin
        if (byte_i == CH_SP) begin
          if (space_hit) begin
            nxt_o.method = space_idx;
            nxt_o.phase  = PH_PATH;
            nxt_o.pos    = '0;
          end else begin
            res_o = '{fire: 1'b1, status: ST_BAD_METHOD};
          end
        end else if (cur_i.pos >= 4'(MAX_METHOD_CHARS)) begin
          res_o = '{fire: 1'b1, status: ST_BAD_METHOD};
        end else if (keep == '0) begin
          res_o = '{fire: 1'b1, status: ST_BAD_METHOD};
        end else begin
          nxt_o.cand = keep;
          nxt_o.pos  = pos_inc;
        end
      end

      PH_PATH: begin
        if (byte_i == CH_CR || byte_i == CH_LF) begin
          res_o = '{fire: 1'b1, status: ST_BAD_LINE};
        end else if (byte_i == CH_SP) begin
          nxt_o.phase = PH_PROTO;
          nxt_o.pos   = '0;
        end
      end

      PH_PROTO: begin
        if (cur_i.pos >= PROTO_LEN || PROTO_TEXT[cur_i.pos[2:0]] != byte_i) begin
          res_o = '{fire: 1'b1, status: ST_BAD_VERSION};
        end else begin
          nxt_o.pos = pos_inc;
          if (pos_inc == PROTO_LEN) nxt_o.phase = PH_MAJOR;
        end
      end

      PH_MAJOR: begin
        if (byte_i == CH_ONE || byte_i == CH_TWO) begin
          nxt_o.major = byte_i[1:0];
          nxt_o.minor = 2'd0;
          nxt_o.phase = PH_DOT;
        end else begin
          res_o = '{fire: 1'b1, status: ST_BAD_VERSION};
        end
      end

      PH_DOT: begin
        if (byte_i == CH_DOT) nxt_o.phase = PH_MINOR;
        else res_o = '{fire: 1'b1, status: ST_BAD_VERSION};
      end

      PH_MINOR: begin
        if (byte_i >= CH_ZERO && byte_i <= CH_TWO) begin
          nxt_o.minor = byte_i[1:0];
          nxt_o.phase = PH_CR;
        end else begin
          res_o = '{fire: 1'b1, status: ST_BAD_VERSION};
        end
      end

      PH_CR: begin
        if (byte_i == CH_CR) nxt_o.phase = PH_LF;
        else res_o = '{fire: 1'b1, status: ST_BAD_LINE};
      end

      PH_LF: begin
        if (byte_i == CH_LF) begin
          nxt_o.phase  = PH_LINE;
          nxt_o.pos    = '0;
          nxt_o.kflags = 2'b11;
        end else begin
          res_o = '{fire: 1'b1, status: ST_BAD_LINE};
        end
      end

      // Start of a header line is the first key byte unless it is a CR
      PH_LINE, PH_KEY: begin
        if (cur_i.phase == PH_LINE && byte_i == CH_CR) begin
          nxt_o.phase = PH_END_LF;
        end else begin
          nxt_o.phase = PH_KEY;
          if (byte_i == CH_CR || byte_i == CH_LF) begin
            res_o = '{fire: 1'b1, status: ST_BAD_HEADER};
          end else if (byte_i == CH_COLON) begin
            nxt_o.kflags[0] = cur_i.kflags[0] && (cur_i.pos == LEN_KEY_LEN);
            nxt_o.kflags[1] = cur_i.kflags[1] && (cur_i.pos == CONN_KEY_LEN);
            nxt_o.phase     = PH_SPACE;
          end else begin
            nxt_o.kflags = cur_i.kflags & {conn_hit, len_hit};
            nxt_o.pos    = pos_inc;
          end
        end
      end

      PH_SPACE: begin
        if (byte_i != CH_SP) begin
          res_o = '{fire: 1'b1, status: ST_BAD_HEADER};
        end else begin
          if (cur_i.kflags[0]) begin
            acc_o       = '0;
            nxt_o.dseen = 1'b0;
          end
          nxt_o.vmatch = 1'b1;
          nxt_o.pos    = '0;
          nxt_o.phase  = PH_VALUE;
        end
      end

      PH_VALUE: begin
        if (byte_i == CH_CR) begin
          nxt_o.phase = PH_VALUE_LF;
        end else if (cur_i.kflags[0]) begin
          if (!is_digit) begin
            res_o = '{fire: 1'b1, status: ST_BAD_LENGTH};
          end else if (ovf) begin
            res_o = '{fire: 1'b1, status: ST_LEN_OVERFLOW};
          end else begin
            acc_o       = prod[LENGTH_WIDTH-1:0];
            nxt_o.dseen = 1'b1;
          end
        end else if (cur_i.kflags[1]) begin
          nxt_o.vmatch = cur_i.vmatch && ka_hit;
          nxt_o.pos    = pos_inc;
        end
      end

      // A CR not followed by LF counts as a value byte
      PH_VALUE_LF: begin
        if (byte_i == CH_LF) begin
          if (cur_i.kflags[0] && !cur_i.dseen) begin
            res_o = '{fire: 1'b1, status: ST_BAD_LENGTH};
          end else begin
            if (cur_i.kflags[1] && cur_i.vmatch && cur_i.pos == KA_LEN)
              nxt_o.kalive = 1'b1;
            nxt_o.phase  = PH_LINE;
            nxt_o.pos    = '0;
            nxt_o.kflags = 2'b11;
          end
        end else if (cur_i.kflags[0]) begin
          res_o = '{fire: 1'b1, status: ST_BAD_LENGTH};
        end else begin
          if (cur_i.kflags[1]) begin
            nxt_o.vmatch = 1'b0;
            nxt_o.pos    = (byte_i == CH_CR) ? pos_inc : pos_inc2;
          end
          if (byte_i != CH_CR) nxt_o.phase = PH_VALUE;
        end
      end

      PH_END_LF: begin
        res_o.fire   = 1'b1;
        res_o.status = (byte_i == CH_LF) ? ST_OK : ST_BAD_HEADER;
      end

      default: begin
        nxt_o = STATE_RESET;
        acc_o = '0;
      end
    endcase

    // A result restarts the parser for the next request
    if (res_o.fire) begin
      nxt_o = STATE_RESET;
      acc_o = '0;
    end
  end

endmodule

// ===== src/hrp_checker.sv =====
// ----------------------------------------------------------------------------
// hrp_checker
// Port-level checks of the request head parser, bound to the top level.
// ----------------------------------------------------------------------------
module hrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [3:0]  method_code_o,
  input logic [1:0]  major_version_o,
  input logic [1:0]  minor_version_o,
  input logic [31:0] body_length_o
);
  import hrp_pkg::*;

  // Stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(body_length_o) && $stable(method_code_o))
    else $error("result changed while stalled");

  // A held result blocks new input transactions
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while result stalled");

  // Status and method code stay in range
  a_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 3'd7 && method_code_o <= 4'd8)
    else $error("result code out of range");

  // A complete head always carries a parsed version
  a_ok_version: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |->
      (major_version_o == 2'd1 || major_version_o == 2'd2) && minor_version_o != 2'd3)
    else $error("ok result without a valid version");

endmodule

bind http_request_head_parser_unit hrp_checker u_hrp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .method_code_o  (method_code_o),
  .major_version_o(major_version_o),
  .minor_version_o(minor_version_o),
  .body_length_o  (body_length_o)
);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for http_request_head_parser_unit. Bytes of HTTP request
// heads are pushed through the input channel with random gaps. A scoreboard
// class tracks the parse state of every accepted byte and queues the result
// that the unit must return. Each returned result is compared field by field.
// The stimulus has a short directed part for the error cases and the limits,
// then mostly well-formed random requests with some noise and broken lines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import hrp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned TARGET_BYTES = 550;

  // One result of the unit
  typedef struct packed {
    status_e     status;
    logic [3:0]  method_code;
    logic [1:0]  major;
    logic [1:0]  minor;
    logic [31:0] body_length;
    logic        persistent;
  } head_result_t;

  // Parse state tracker plus the queue of results still owed by the unit
  class parse_scoreboard;
    string        verbs[9];
    string        proto_text, len_key, conn_key, ka_text;
    phase_e       phase;
    logic [3:0]   pos;
    logic [8:0]   cand;
    logic [1:0]   kflags;  // bit 0 Content-Length, bit 1 Connection
    logic         vmatch, dseen, kalive;
    logic [3:0]   method;
    logic [1:0]   major, minor;
    logic [31:0]  length;
    head_result_t due_results[$];
    int unsigned  checked, errors, kalive_count;
    int unsigned  status_count[8];

    function new();
      verbs = '{"GET", "HEAD", "POST", "PUT", "DELETE", "CONNECT", "OPTIONS", "TRACE",
                "PATCH"};
      proto_text = "HTTP/";
      len_key    = "Content-Length";
      conn_key   = "Connection";
      ka_text    = "Keep-Alive";
      restart();
    endfunction

    function void restart();
      phase  = PH_METHOD;
      pos    = '0;
      cand   = '1;
      kflags = 2'b11;
      vmatch = 1'b1;
      dseen  = 1'b0;
      kalive = 1'b0;
      method = '0;
      major  = '0;
      minor  = '0;
      length = '0;
    endfunction

    function void start_line();
      phase  = PH_LINE;
      pos    = '0;
      kflags = 2'b11;
    endfunction

    // Queue the result for the gathered fields, then start over
    function void emit(status_e st);
      head_result_t r;
      r.status      = st;
      r.method_code = method;
      r.major       = major;
      r.minor       = minor;
      r.body_length = length;
      r.persistent  = kalive;
      due_results.push_back(r);
      restart();
    endfunction

    // One value byte; ST_OK means no error
    function status_e value_byte(logic [7:0] b);
      longint unsigned digit;
      if (kflags[0]) begin
        if (b < CH_ZERO || b > CH_NINE) return ST_BAD_LENGTH;
        digit = 64'(b - CH_ZERO);
        if (64'(length) > (64'hFFFF_FFFF - digit) / 10) return ST_LEN_OVERFLOW;
        length = 32'(64'(length) * 10 + digit);
        dseen  = 1'b1;
      end else if (kflags[1]) begin
        if (!(pos < 4'd10 && b == ka_text[pos])) vmatch = 1'b0;
        if (pos != 4'd15) pos++;
      end
      return ST_OK;
    endfunction

    // Advance the parse state by one accepted byte
    function void take_byte(logic [7:0] b);
      status_e err;
      // First byte of a line: CR starts the empty line, anything else a key
      if (phase == PH_LINE) begin
        if (b == CH_CR) begin
          phase = PH_END_LF;
          return;
        end
        phase = PH_KEY;
      end
      case (phase)
        PH_METHOD: begin
          if (b == CH_SP) begin
            for (int i = 0; i < 9; i++) begin
              if (cand[i] && verbs[i].len() == int'(pos)) begin
                method = 4'(i);
                phase  = PH_PATH;
                pos    = '0;
                return;
              end
            end
            emit(ST_BAD_METHOD);
          end else if (pos >= MAX_METHOD_CHARS) begin
            emit(ST_BAD_METHOD);
          end else begin
            for (int i = 0; i < 9; i++) begin
              if (!(int'(pos) < verbs[i].len() && b == verbs[i][pos])) cand[i] = 1'b0;
            end
            if (cand == '0) emit(ST_BAD_METHOD);
            else pos++;
          end
        end
        PH_PATH: begin
          if (b == CH_CR || b == CH_LF) begin
            emit(ST_BAD_LINE);
          end else if (b == CH_SP) begin
            phase = PH_PROTO;
            pos   = '0;
          end
        end
        PH_PROTO: begin
          if (pos >= 4'd5 || b != proto_text[pos]) begin
            emit(ST_BAD_VERSION);
          end else begin
            pos++;
            if (pos == 4'd5) phase = PH_MAJOR;
          end
        end
        PH_MAJOR: begin
          if (b != CH_ONE && b != CH_TWO) begin
            emit(ST_BAD_VERSION);
          end else begin
            major = 2'(b - CH_ZERO);
            minor = '0;
            phase = PH_DOT;
          end
        end
        PH_DOT: begin
          if (b != CH_DOT) emit(ST_BAD_VERSION);
          else phase = PH_MINOR;
        end
        PH_MINOR: begin
          if (b < CH_ZERO || b > CH_TWO) begin
            emit(ST_BAD_VERSION);
          end else begin
            minor = 2'(b - CH_ZERO);
            phase = PH_CR;
          end
        end
        PH_CR: begin
          if (b != CH_CR) emit(ST_BAD_LINE);
          else phase = PH_LF;
        end
        PH_LF: begin
          if (b != CH_LF) emit(ST_BAD_LINE);
          else start_line();
        end
        PH_KEY: begin
          if (b == CH_CR || b == CH_LF) begin
            emit(ST_BAD_HEADER);
          end else if (b == CH_COLON) begin
            kflags = {kflags[1] && pos == 4'd10, kflags[0] && pos == 4'd14};
            phase  = PH_SPACE;
          end else begin
            if (!(pos < 4'd14 && b == len_key[pos])) kflags[0] = 1'b0;
            if (!(pos < 4'd10 && b == conn_key[pos])) kflags[1] = 1'b0;
            if (pos != 4'd15) pos++;
          end
        end
        PH_SPACE: begin
          if (b != CH_SP) begin
            emit(ST_BAD_HEADER);
          end else begin
            if (kflags[0]) begin
              length = '0;
              dseen  = 1'b0;
            end
            vmatch = 1'b1;
            pos    = '0;
            phase  = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (b == CH_CR) begin
            phase = PH_VALUE_LF;
          end else begin
            err = value_byte(b);
            if (err != ST_OK) emit(err);
          end
        end
        PH_VALUE_LF: begin
          if (b == CH_LF) begin
            if (kflags[0] && !dseen) begin
              emit(ST_BAD_LENGTH);
            end else begin
              if (kflags[1] && vmatch && pos == 4'd10) kalive = 1'b1;
              start_line();
            end
          end else begin
            // lone CR belongs to the value
            err = value_byte(CH_CR);
            if (err != ST_OK) begin
              emit(err);
            end else if (b != CH_CR) begin
              phase = PH_VALUE;
              err   = value_byte(b);
              if (err != ST_OK) emit(err);
            end
          end
        end
        PH_END_LF: emit((b == CH_LF) ? ST_OK : ST_BAD_HEADER);
        default: restart();
      endcase
    endfunction

    // Compare a returned result with the oldest one owed
    function void check_result(head_result_t got);
      head_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result: status %0d method %0d ver %0d.%0d len %0d ka %0d",
                   got.status, got.method_code, got.major, got.minor, got.body_length,
                   got.persistent);
        return;
      end
      want = due_results.pop_front();
      checked++;
      status_count[want.status]++;
      if (want.persistent) kalive_count++;
      if (got.status !== want.status || got.method_code !== want.method_code ||
          got.major !== want.major || got.minor !== want.minor ||
          got.body_length !== want.body_length || got.persistent !== want.persistent) begin
        errors++;
        if (errors <= 10)
          $display({"ERROR: result %0d (exp/act): status %0d/%0d method %0d/%0d ",
                     "major %0d/%0d minor %0d/%0d len %0d/%0d ka %0d/%0d"},
                    checked, want.status, got.status, want.method_code, got.method_code,
                    want.major, got.major, want.minor, got.minor,
                    want.body_length, got.body_length, want.persistent, got.persistent);
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  method_code_o;
  logic [1:0]  major_version_o;
  logic [1:0]  minor_version_o;
  logic [31:0] body_length_o;
  logic        persistent_o;

  parse_scoreboard sb = new();
  logic [7:0]      burst[$];
  int unsigned     bytes_sent   = 0;
  int unsigned     tx_gap_pct   = 0;
  int unsigned     rx_stall_pct = 0;
  int unsigned     rx_hold      = 0;
  int unsigned     cycles       = 0;
  string           crlf, cr;

  http_request_head_parser_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .method_code_o  (method_code_o),
    .major_version_o(major_version_o),
    .minor_version_o(minor_version_o),
    .body_length_o  (body_length_o),
    .persistent_o   (persistent_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.due_results.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Transaction monitor: both channels sampled at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(head_result_t'{status: status_e'(status_o), method_code: method_code_o,
                                     major: major_version_o, minor: minor_version_o,
                                     body_length: body_length_o, persistent: persistent_o});
    if (rst_ni && in_valid_i && in_ready_o) sb.take_byte(in_byte_i);
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls plus an occasional long hold-off
  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < rx_stall_pct) stall_left = pick_gap();
      end
    end
  end

  // Offer one byte and wait for its transaction; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < tx_gap_pct) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic flush_burst();
    while (burst.size() != 0) send_byte(burst.pop_front());
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) burst.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
  endfunction

  function automatic string rand_word(int unsigned max_len);
    string s;
    s = "";
    repeat ($urandom_range(0, max_len)) s = {s, string'(rand_letter())};
    return s;
  endfunction

  // Method, mostly a real one
  function automatic void add_method();
    string       m;
    int unsigned r;
    r = $urandom_range(0, 99);
    m = sb.verbs[$urandom_range(0, 8)];
    if (r < 6) m[$urandom_range(0, m.len() - 1)] = rand_letter();
    else if (r < 9) m = m.substr(0, $urandom_range(0, m.len() - 2));
    else if (r < 11) m = {sb.verbs[$urandom_range(5, 6)], string'(rand_letter())};
    else if (r < 13) burst.push_back(8'($urandom_range(0, 255)));
    add_text({m, " "});
  endfunction

  // Path: printable text with some raw bytes, rarely a line break
  function automatic void add_path();
    logic [7:0] b;
    add_text("/");
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 99) < 12) begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_SP || b == CH_CR || b == CH_LF);
      end else begin
        b = 8'($urandom_range(33, 126));
      end
      burst.push_back(b);
    end
    if ($urandom_range(0, 99) < 2) add_text(cr);
    add_text(" ");
  endfunction

  function automatic void add_version();
    string v;
    v = "HTTP/";
    if ($urandom_range(0, 99) < 3) v[$urandom_range(0, 4)] = rand_letter();
    v = {v, ($urandom_range(0, 99) < 95) ? $sformatf("%0d", $urandom_range(1, 2))
                                         : $sformatf("%0d", $urandom_range(0, 9))};
    v = {v, ($urandom_range(0, 99) < 97) ? "." : ","};
    v = {v, ($urandom_range(0, 99) < 95) ? $sformatf("%0d", $urandom_range(0, 2))
                                         : $sformatf("%0d", $urandom_range(0, 9))};
    v = {v, ($urandom_range(0, 99) < 97) ? crlf : "x"};
    add_text(v);
  endfunction

  function automatic string length_text();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $sformatf("%0d", $urandom_range(0, 9999));
      4: return $sformatf("%0d", $urandom());
      5: return $sformatf("%0d", 64'd4294967295 + 64'($urandom_range(0, 3)));
      6: return "";
      7: return ($urandom_range(0, 1) != 0) ? {"12", string'(rand_letter()), "3"} : {"4", cr, "5"};
      8: return $sformatf("000%0d", $urandom_range(0, 99));
      default: return $sformatf("%0d", {$urandom(), $urandom()});
    endcase
  endfunction

  function automatic string conn_value_text();
    case ($urandom_range(0, 9))
      6: return "keep-alive";
      7: return "Keep-Alive ";
      8: return "Keep-Aliv";
      9: return "close";
      default: return "Keep-Alive";
    endcase
  endfunction

  // One header line; half of them the keys that matter, some broken ones
  function automatic void add_header();
    string       key, value;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      key   = "Content-Length";
      value = length_text();
    end else if (kind < 5) begin
      key   = "Connection";
      value = conn_value_text();
    end else begin
      key   = rand_word(8);
      value = rand_word(6);
      if ($urandom_range(0, 9) == 0) value = {value, cr, "x", rand_word(3)};
      if ($urandom_range(0, 19) == 0) value = {value, cr, cr, "y"};
    end
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: key = key.substr(0, key.len() - 2);
        1: key = {key, "s"};
        default: key = {"x", key};
      endcase
    end
    if ($urandom_range(0, 49) == 0) key = {key, cr};
    add_text({key, ($urandom_range(0, 99) < 97) ? ": " : ":x", value, crlf});
  endfunction

  function automatic void add_request();
    if ($urandom_range(0, 99) < 4)
      repeat ($urandom_range(1, 6)) burst.push_back(8'($urandom_range(0, 255)));
    add_method();
    add_path();
    add_version();
    repeat ($urandom_range(0, 3)) add_header();
    add_text(($urandom_range(0, 99) < 96) ? crlf : {cr, "x"});
  endfunction

  initial begin : stimulus
    string       head;
    int unsigned req;
    int unsigned pct_choice[4];
    pct_choice = '{0, 10, 30, 70};
    crlf = $sformatf("%c%c", CH_CR, CH_LF);
    cr   = $sformatf("%c", CH_CR);
    head = {"GET / HTTP/1.1", crlf};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: byte extremes, every method, each error and the value limits
    burst.push_back(8'h00);
    burst.push_back(8'hFF);
    add_text("GETX");
    add_text("GE ");
    add_text("CONNECTS");
    for (int i = 0; i < 9; i++) add_text({sb.verbs[i], "  Z"});
    add_text({"GET /a", cr});
    add_text("HEAD /");
    burst.push_back(8'h00);
    burst.push_back(8'hFF);
    add_text(" HTTP/3");
    add_text("PUT / HTTP/2.3");
    add_text("PUT / HTTP/2x");
    add_text("PUT / HTTP/1.1X");
    add_text({"POST / HTTP/1.0", crlf, "Content-Length: 4294967295", crlf,
              "Connection: Keep-Alive", crlf, ": v", crlf, crlf});
    add_text({head, "Content-Length: 4294967296", crlf});
    add_text({head, "Content-Length: ", crlf});
    add_text({head, "Content-Length: 1x"});
    add_text({head, "X", cr});
    add_text({head, "Ab:c"});
    add_text({head, cr, "Q"});
    add_text({head, "A: b", cr, "c", crlf, "Content-Length: 7", crlf, "Content-Length: 12",
              crlf, "Connection: Keep-Alive2", crlf, crlf});
    flush_burst();

    // Random requests, idling profile changes every few requests
    req = 0;
    while (bytes_sent < TARGET_BYTES) begin
      if (req % 8 == 0) begin
        tx_gap_pct   = pct_choice[$urandom_range(0, 3)];
        rx_stall_pct = pct_choice[$urandom_range(0, 3)];
      end
      // long receiver hold-off so the result register fills and input stalls
      if (req == 4 || req == 40) rx_hold = 300;
      add_request();
      flush_burst();
      req++;
    end
    in_valid_i <= 1'b0;

    // Drain
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("summary: %0d bytes over %0d random requests, %0d results checked, %0d keep-alive",
             bytes_sent, req, sb.checked, sb.kalive_count);
    $display("summary: ok %0d method %0d line %0d version %0d header %0d length %0d ovf %0d",
             sb.status_count[ST_OK], sb.status_count[ST_BAD_METHOD],
             sb.status_count[ST_BAD_LINE], sb.status_count[ST_BAD_VERSION],
             sb.status_count[ST_BAD_HEADER], sb.status_count[ST_BAD_LENGTH],
             sb.status_count[ST_LEN_OVERFLOW]);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d errors", sb.errors);
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/hrp_pkg.sv
src/hrp_step.sv
src/http_request_head_parser_unit.sv
src/hrp_checker.sv
dv/tb_top.sv
